// ===== rtl/cbs_pkg.sv =====
// Shared constants for the cubic Bezier subdivider.
// No dependencies; the top level takes its defaults from here.
package cbs_pkg;

    // Default stack depth, also the largest subdivision depth.
    localparam int MAX_DEPTH_DEF   = 6;
    // Default coordinate width, signed fixed point with 8 fraction bits.
    localparam int COORD_WIDTH_DEF = 24;
    // Coordinates in one curve: x0 y0 x1 y1 x2 y2 x3 y3.
    localparam int NUM_COORDS      = 8;
    // Width of the depth register and of every level count.
    localparam int LEVEL_W         = 3;
    // Depth register value after reset.
    localparam logic [LEVEL_W-1:0] DEPTH_RESET = 3'd3;

endpackage

// ===== rtl/cbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cbs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cubic_bezier_subdivider_top.sv =====
// Cubic Bezier subdivider: midpoint flattening of one curve into 2^depth chords.
// Depends on cbs_pkg and on cbs_ram, which holds the stack of deferred right halves.
// Throughput: one curve at a time; the input stalls until the last segment of a
// curve is loaded into the output register. Each split passes through the
// registered midpoint chain (states SPLIT_A, SPLIT_B, SPLIT_C), each leaf waits
// for a free output register, each pop reads the stack RAM, and the idle state
// takes the next curve.
// Reset (synchronous, active low) empties the stack, clears the output valid flag
// and sets the depth register to 3; the stack RAM contents are not cleared.
module cubic_bezier_subdivider_top #(
    parameter int MAX_DEPTH   = cbs_pkg::MAX_DEPTH_DEF,
    parameter int COORD_WIDTH = cbs_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port for the depth register.
    input  logic                              i_cfg_we,
    input  logic [cbs_pkg::LEVEL_W-1:0]       i_cfg_data,
    // Input channel: one curve per word.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]     i_p0_x,
    input  logic signed [COORD_WIDTH-1:0]     i_p0_y,
    input  logic signed [COORD_WIDTH-1:0]     i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]     i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]     i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]     i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]     i_p3_x,
    input  logic signed [COORD_WIDTH-1:0]     i_p3_y,
    // Output channel: one segment per word.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [COORD_WIDTH-1:0]     o_seg_start_x,
    output logic signed [COORD_WIDTH-1:0]     o_seg_start_y,
    output logic signed [COORD_WIDTH-1:0]     o_seg_end_x,
    output logic signed [COORD_WIDTH-1:0]     o_seg_end_y,
    output logic                              o_last_segment
);

    localparam int CW    = COORD_WIDTH;
    localparam int NC    = cbs_pkg::NUM_COORDS;
    localparam int LW    = cbs_pkg::LEVEL_W;
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SPW   = $clog2(MAX_DEPTH + 1);
    localparam int RAM_W = NC * CW + LW;

    localparam logic [LW-1:0]  DEPTH_MAX = LW'(MAX_DEPTH);
    localparam logic [SPW-1:0] SP_MAX    = SPW'(MAX_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SPLIT_A = 3'd1;
    localparam logic [2:0] S_SPLIT_B = 3'd2;
    localparam logic [2:0] S_SPLIT_C = 3'd3;
    localparam logic [2:0] S_LEAF    = 3'd4;
    localparam logic [2:0] S_POP     = 3'd5;

    // Midpoint as floor((a + b) / 2): full-precision sum, arithmetic shift by one.
    function automatic logic signed [CW-1:0] f_mid(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    logic [2:0]                r_state;
    logic [LW-1:0]             r_cfg_depth;
    logic [SPW-1:0]            r_sp;
    logic [LW-1:0]             r_lvl;
    logic signed [CW-1:0]      r_wc [NC];
    logic signed [CW-1:0]      r_ma [2];
    logic signed [CW-1:0]      r_mb [2];
    logic signed [CW-1:0]      r_mc [2];
    logic signed [CW-1:0]      r_m4 [2];
    logic signed [CW-1:0]      r_m5 [2];
    logic                      r_o_valid;
    logic signed [CW-1:0]      r_o_sx;
    logic signed [CW-1:0]      r_o_sy;
    logic signed [CW-1:0]      r_o_ex;
    logic signed [CW-1:0]      r_o_ey;
    logic                      r_o_last;

    logic signed [CW-1:0]      w_m6 [2];
    logic [LW-1:0]             w_depth_sat;
    logic [LW-1:0]             w_lvl_dec;
    logic [SPW-1:0]            w_sp_dec;
    logic                      w_out_free;
    logic                      w_in_take;
    logic                      w_ram_we;
    logic [RAM_W-1:0]          w_wdata;
    logic [RAM_W-1:0]          w_rdata;
    logic [LW-1:0]             w_pop_lvl;

    assign w_depth_sat = (r_cfg_depth > DEPTH_MAX) ? DEPTH_MAX : r_cfg_depth;
    assign w_lvl_dec   = r_lvl - 1'b1;
    assign w_sp_dec    = r_sp - 1'b1;
    // The output register can take a new word when empty or when its word leaves now.
    assign w_out_free  = !r_o_valid || !i_out_stall;
    assign w_in_take   = i_in_valid && (r_state == S_IDLE);
    assign w_ram_we    = (r_state == S_SPLIT_C);
    assign w_pop_lvl   = w_rdata[NC*CW +: LW];

    assign w_m6[0] = f_mid(r_m4[0], r_m5[0]);
    assign w_m6[1] = f_mid(r_m4[1], r_m5[1]);

    // The right half goes onto the stack: m6, m5, m3 and the end point.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_wdata[c*CW       +: CW] = w_m6[c];
            w_wdata[(2+c)*CW   +: CW] = r_m5[c];
            w_wdata[(4+c)*CW   +: CW] = r_mc[c];
            w_wdata[(6+c)*CW   +: CW] = r_wc[6+c];
        end
        w_wdata[NC*CW +: LW] = w_lvl_dec;
    end

    // The push of an entry always lands in the RAM before its pop reads it, so
    // the registered read never needs forwarding.
    cbs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_DEPTH),
        .ADDR_W(AW)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_sp[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(w_sp_dec[AW-1:0]),
        .o_rdata(w_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_depth <= cbs_pkg::DEPTH_RESET;
            r_sp        <= '0;
            r_lvl       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_depth <= i_cfg_data;
            end
            // A leaf loads the output register; otherwise a word that leaves empties it.
            if ((r_state == S_LEAF) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_lvl   <= w_depth_sat;
                        r_sp    <= '0;
                        r_state <= (w_depth_sat == '0) ? S_LEAF : S_SPLIT_A;
                    end
                end
                S_SPLIT_A: r_state <= S_SPLIT_B;
                S_SPLIT_B: r_state <= S_SPLIT_C;
                S_SPLIT_C: begin
                    r_lvl   <= w_lvl_dec;
                    r_sp    <= r_sp + 1'b1;
                    r_state <= (w_lvl_dec == '0) ? S_LEAF : S_SPLIT_A;
                end
                S_LEAF: begin
                    if (w_out_free) begin
                        if (r_sp == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            // The read of the top entry is issued in this cycle.
                            r_sp    <= w_sp_dec;
                            r_state <= S_POP;
                        end
                    end
                end
                S_POP: begin
                    r_lvl   <= w_pop_lvl;
                    r_state <= (w_pop_lvl == '0) ? S_LEAF : S_SPLIT_A;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: working curve, midpoint stages and output word.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    r_wc[0] <= i_p0_x;
                    r_wc[1] <= i_p0_y;
                    r_wc[2] <= i_p1_x;
                    r_wc[3] <= i_p1_y;
                    r_wc[4] <= i_p2_x;
                    r_wc[5] <= i_p2_y;
                    r_wc[6] <= i_p3_x;
                    r_wc[7] <= i_p3_y;
                end
            end
            S_SPLIT_A: begin
                for (int c = 0; c < 2; c++) begin
                    r_ma[c] <= f_mid(r_wc[c],   r_wc[2+c]);
                    r_mb[c] <= f_mid(r_wc[2+c], r_wc[4+c]);
                    r_mc[c] <= f_mid(r_wc[4+c], r_wc[6+c]);
                end
            end
            S_SPLIT_B: begin
                for (int c = 0; c < 2; c++) begin
                    r_m4[c] <= f_mid(r_ma[c], r_mb[c]);
                    r_m5[c] <= f_mid(r_mb[c], r_mc[c]);
                end
            end
            S_SPLIT_C: begin
                // The left half stays in the working registers.
                for (int c = 0; c < 2; c++) begin
                    r_wc[2+c] <= r_ma[c];
                    r_wc[4+c] <= r_m4[c];
                    r_wc[6+c] <= w_m6[c];
                end
            end
            S_LEAF: begin
                if (w_out_free) begin
                    r_o_sx   <= r_wc[0];
                    r_o_sy   <= r_wc[1];
                    r_o_ex   <= r_wc[6];
                    r_o_ey   <= r_wc[7];
                    r_o_last <= (r_sp == '0);
                end
            end
            S_POP: begin
                for (int i = 0; i < NC; i++) begin
                    r_wc[i] <= w_rdata[i*CW +: CW];
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_seg_start_x  = r_o_sx;
    assign o_seg_start_y  = r_o_sy;
    assign o_seg_end_x    = r_o_ex;
    assign o_seg_end_y    = r_o_ey;
    assign o_last_segment = r_o_last;

    // The stack never holds more entries than the largest depth.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_MAX)
        else $error("stack pointer beyond its depth");

    // A push only happens while there is room on the stack.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT_C) |-> (r_sp < SP_MAX))
        else $error("push onto a full stack");

    // Between curves the stack is empty.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_sp == '0))
        else $error("stack not empty while idle");

    // A leaf waits while the output word is held back.
    a_leaf_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEAF && r_o_valid && i_out_stall) |=> (r_state == S_LEAF))
        else $error("leaf left while the output register was full");

    // Remaining levels never exceed the largest depth.
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_lvl <= DEPTH_MAX))
        else $error("level count out of range");

endmodule
